// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the converter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, off while reset is held
`define Y2R_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies a consequence in the next
`define Y2R_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ----- hw/rtl/y2r_pkg.sv -----
// shared types and constants for the yuyv to rgb24 converter
`timescale 1ns / 1ps

package y2r_pkg;

    // bytes of colour made from one yuyv pair
    localparam int BYTES_PER_PAIR = 6;
    // most pad bytes after one row
    localparam int PAD_LIMIT      = 2;
    // row count limit and widths
    localparam int HEIGHT_CAP     = 4096;
    localparam int ROW_W          = 12;
    localparam int CFG_W          = 13;
    localparam int PAD_W          = 2;

    // geometry after reset
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;

    // register indexes of the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // chroma offset and colour matrix coefficients (q8)
    localparam logic [7:0]        CHROMA_BIAS = 8'h80;
    localparam logic [7:0]        BYTE_MAX    = 8'hFF;
    localparam logic signed [8:0] K_R_V       = 9'sd103;
    localparam logic signed [8:0] K_G_U       = 9'sd88;
    localparam logic signed [8:0] K_G_V       = 9'sd183;
    localparam logic signed [8:0] K_B_U       = 9'sd198;

    typedef logic [PAD_W-1:0] pad_cnt_t;

    // one converted pair: b0 g0 r0 b1 g1 r1 from index 0 up
    typedef struct packed {
        logic [BYTES_PER_PAIR-1:0][7:0] colour;
        pad_cnt_t                       pad_cnt;
        logic                           row_done;
        logic                           frame_done;
    } y2r_entry_t;

endpackage

// ----- hw/rtl/y2r_queue.sv -----
// two-entry queue between the pair front end and the byte back end
`timescale 1ns / 1ps
`include "assert_macros.svh"

module y2r_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  y2r_pkg::y2r_entry_t    push_entry,
    output logic                   push_ready,
    output logic                   q_valid,
    output y2r_pkg::y2r_entry_t    q_entry,
    input  logic                   pop
);

    y2r_pkg::y2r_entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // status
    assign push_ready = (count_reg != 2'd2);
    assign q_valid    = (count_reg != 2'd0);
    assign q_entry    = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `Y2R_ASSERT_NEXT(a_q_fill, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + 2'd1, "queue fill count did not grow on push")

endmodule

// ----- hw/rtl/y2r_front.sv -----
// front end: takes yuyv pairs, works out colours and row position
`timescale 1ns / 1ps
`include "assert_macros.svh"

module y2r_front #(
    parameter int PAIR_W = 11
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,
    input  logic [PAIR_W-1:0]             pairs_last,
    input  logic [y2r_pkg::ROW_W-1:0]     rows_last,
    input  y2r_pkg::pad_cnt_t             pad_cnt,
    input  logic                          q_ready,
    output logic                          q_push,
    output y2r_pkg::y2r_entry_t           q_entry
);

    // saturate luma plus colour offset into a byte
    function automatic logic [7:0] chan_sat(input logic [7:0] y, input logic signed [9:0] d);
        logic signed [10:0] s;
        s = $signed({3'b000, y}) + 11'(d);
        if (s[10]) begin
            chan_sat = 8'h00;
        end else if (s[9:8] != 2'b00) begin
            chan_sat = y2r_pkg::BYTE_MAX;
        end else begin
            chan_sat = s[7:0];
        end
    endfunction

    logic accept, advance;
    logic [7:0] y0, y1;
    logic signed [7:0]  u_s, v_s;
    logic signed [16:0] p_rv, p_gu, p_gv, p_bu;
    logic signed [8:0]  q_rv, q_gu, q_gv, q_bu;
    logic signed [9:0]  rd, gd, bd;
    logic row_done, frame_done;

    logic [PAIR_W-1:0]          pair_col_reg, pair_col_next;
    logic [y2r_pkg::ROW_W-1:0]  row_idx_reg, row_idx_next;
    logic                       stg_valid_reg, stg_valid_next;
    logic [7:0]                 y0_reg, y1_reg;
    logic signed [9:0]          rd_reg, gd_reg, bd_reg;
    logic                       row_done_reg, frame_done_reg;
    y2r_pkg::pad_cnt_t          pad_reg;

    // beat handshake and stage advance
    assign advance  = stg_valid_reg && q_ready;
    assign s_tready = !stg_valid_reg || q_ready;
    assign accept   = s_tvalid && s_tready;

    // unpack the pair and remove the chroma offset
    assign y0  = s_tdata[7:0];
    assign y1  = s_tdata[23:16];
    assign u_s = $signed(s_tdata[15:8] ^ y2r_pkg::CHROMA_BIAS);
    assign v_s = $signed(s_tdata[31:24] ^ y2r_pkg::CHROMA_BIAS);

    // constant products, floor shift by eight
    assign p_rv = v_s * y2r_pkg::K_R_V;
    assign p_gu = u_s * y2r_pkg::K_G_U;
    assign p_gv = v_s * y2r_pkg::K_G_V;
    assign p_bu = u_s * y2r_pkg::K_B_U;
    assign q_rv = p_rv[16:8];
    assign q_gu = p_gu[16:8];
    assign q_gv = p_gv[16:8];
    assign q_bu = p_bu[16:8];

    // shared colour offsets of the pair
    assign rd = 10'(v_s) + 10'(q_rv);
    assign gd = -10'(q_gu) - 10'(q_gv);
    assign bd = 10'(u_s) + 10'(q_bu);

    // row and frame position
    assign row_done   = (pair_col_reg >= pairs_last);
    assign frame_done = row_done && (row_idx_reg >= rows_last);

    always_comb begin
        pair_col_next = pair_col_reg;
        row_idx_next  = row_idx_reg;
        if (accept) begin
            if (row_done) begin
                pair_col_next = '0;
                row_idx_next  = frame_done ? '0 : row_idx_reg + y2r_pkg::ROW_W'(1);
            end else begin
                pair_col_next = pair_col_reg + PAIR_W'(1);
            end
        end
    end

    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (accept) begin
            stg_valid_next = 1'b1;
        end else if (advance) begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_col_reg  <= '0;
            row_idx_reg   <= '0;
            stg_valid_reg <= 1'b0;
        end else begin
            pair_col_reg  <= pair_col_next;
            row_idx_reg   <= row_idx_next;
            stg_valid_reg <= stg_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            y0_reg         <= y0;
            y1_reg         <= y1;
            rd_reg         <= rd;
            gd_reg         <= gd;
            bd_reg         <= bd;
            row_done_reg   <= row_done;
            frame_done_reg <= frame_done;
            pad_reg        <= row_done ? pad_cnt : '0;
        end
    end

    // final colour bytes into the queue
    assign q_push = advance;
    always_comb begin
        q_entry.colour[0]  = chan_sat(y0_reg, bd_reg);
        q_entry.colour[1]  = chan_sat(y0_reg, gd_reg);
        q_entry.colour[2]  = chan_sat(y0_reg, rd_reg);
        q_entry.colour[3]  = chan_sat(y1_reg, bd_reg);
        q_entry.colour[4]  = chan_sat(y1_reg, gd_reg);
        q_entry.colour[5]  = chan_sat(y1_reg, rd_reg);
        q_entry.pad_cnt    = pad_reg;
        q_entry.row_done   = row_done_reg;
        q_entry.frame_done = frame_done_reg;
    end

    `Y2R_ASSERT_NEXT(a_col_step, aclk, aresetn, accept && !row_done,
        pair_col_reg == $past(pair_col_reg) + PAIR_W'(1), "pair column did not step")

endmodule

// ----- hw/rtl/y2r_back.sv -----
// back end: sends the queued pair one byte per beat, then row padding
`timescale 1ns / 1ps
`include "assert_macros.svh"

module y2r_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  y2r_pkg::y2r_entry_t   q_entry,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic [2:0]            m_tuser
);

    logic [2:0] byte_idx_reg, byte_idx_next;
    logic [2:0] last_idx;
    logic       load, is_last;
    logic [7:0] sel_byte;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] data_reg;
    logic       pad_flag_reg, last_reg, row_end_reg, frame_end_reg;

    // position of the last beat of this entry
    assign last_idx = 3'(y2r_pkg::BYTES_PER_PAIR - 1) + 3'(q_entry.pad_cnt);
    assign load     = q_valid && (!m_tvalid_reg || m_tready);
    assign is_last  = (byte_idx_reg == last_idx);
    assign q_pop    = load && is_last;

    // colour byte or zero pad
    always_comb begin
        case (byte_idx_reg)
            3'd0:    sel_byte = q_entry.colour[0];
            3'd1:    sel_byte = q_entry.colour[1];
            3'd2:    sel_byte = q_entry.colour[2];
            3'd3:    sel_byte = q_entry.colour[3];
            3'd4:    sel_byte = q_entry.colour[4];
            3'd5:    sel_byte = q_entry.colour[5];
            default: sel_byte = 8'h00;
        endcase
    end

    always_comb begin
        byte_idx_next = byte_idx_reg;
        if (load) begin
            byte_idx_next = is_last ? 3'd0 : byte_idx_reg + 3'd1;
        end
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_idx_reg <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            byte_idx_reg <= byte_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg      <= sel_byte;
            pad_flag_reg  <= (byte_idx_reg >= 3'(y2r_pkg::BYTES_PER_PAIR));
            last_reg      <= is_last;
            row_end_reg   <= is_last && q_entry.row_done;
            frame_end_reg <= is_last && q_entry.frame_done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = row_end_reg;
    assign m_tuser  = {frame_end_reg, last_reg, pad_flag_reg};

    `Y2R_ASSERT(a_frame_end_row, aclk, aresetn,
        m_tvalid_reg && frame_end_reg |-> row_end_reg && last_reg,
        "frame end without row end on the same beat")
    `Y2R_ASSERT(a_idx_range, aclk, aresetn, q_valid |-> byte_idx_reg <= last_idx,
        "byte index ran past the entry")
    `Y2R_ASSERT(a_idx_idle, aclk, aresetn, !q_valid |-> byte_idx_reg == 3'd0,
        "byte index not parked while queue is empty")

endmodule

// ----- hw/rtl/yuyv_to_rgb24_converter.sv -----
// top level of the yuyv 4:2:2 to 24-bit bgr byte stream converter
//
//  port group   dir  payload
//  s_*          in   tdata: luma_first, chroma_blue, luma_second, chroma_red
//  m_*          out  tdata: out_byte; tlast: row_end;
//                    tuser: is_padding, last_of_item, frame_end
//  cfg_*        in   index 0 frame_width, index 1 frame_height
//
//  each pair leaves as 6 beats, plus 0..2 pad beats at a row end
//  the back end sends one byte per cycle while m_tready is high and a pair is queued
//  a pair passes the front-end stage register and the queue before the output register
//  the front end keeps taking pairs while the two-entry queue has room
//  aresetn is synchronous; reset loads 640 x 480 and clears the position
`timescale 1ns / 1ps

module yuyv_to_rgb24_converter #(
    parameter int ROW_PIXELS_MAX = 4096,
    parameter int ROW_ALIGN = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // luma_first, chroma_blue, luma_second, chroma_red
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // out_byte
    output logic                        m_tlast,
    output logic [2:0]                  m_tuser,   // is_padding, last_of_item, frame_end
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [y2r_pkg::CFG_W-1:0]   cfg_wdata
);

    // widths of the row geometry
    localparam int WIDTH_TOP  = (ROW_PIXELS_MAX > 8191) ? 8191 : ROW_PIXELS_MAX;
    localparam int PAIRS_TOP  = (WIDTH_TOP + 1) / 2;
    localparam int PAIR_W     = (PAIRS_TOP > 1) ? $clog2(PAIRS_TOP) : 1;
    localparam int CW         = y2r_pkg::CFG_W;
    localparam int PB         = y2r_pkg::BYTES_PER_PAIR;

    // geometry loaded at reset
    localparam int RST_W0     = (y2r_pkg::RESET_WIDTH < 2) ? 2 : y2r_pkg::RESET_WIDTH;
    localparam int RST_W      = (RST_W0 > WIDTH_TOP) ? WIDTH_TOP : RST_W0;
    localparam int RST_PAIRS  = (RST_W + 1) / 2;
    localparam int RST_RES    = (PB * RST_PAIRS) % ROW_ALIGN;
    localparam int RST_PADR   = (RST_RES == 0) ? 0 : ROW_ALIGN - RST_RES;
    localparam int RST_PAD    = (RST_PADR > y2r_pkg::PAD_LIMIT) ? y2r_pkg::PAD_LIMIT : RST_PADR;

    // multiples of the alignment for the residue reduction
    localparam logic [6:0] ALIGN_X8 = 7'(8 * ROW_ALIGN);
    localparam logic [6:0] ALIGN_X4 = 7'(4 * ROW_ALIGN);
    localparam logic [6:0] ALIGN_X2 = 7'(2 * ROW_ALIGN);
    localparam logic [6:0] ALIGN_X1 = 7'(ROW_ALIGN);

    logic [PAIR_W-1:0]              pairs_last_reg, pairs_last_next;
    logic [y2r_pkg::ROW_W-1:0]      rows_last_reg, rows_last_next;
    y2r_pkg::pad_cnt_t              pad_reg, pad_next;

    logic [CW-1:0]  w_clamped, h_clamped;
    logic [CW:0]    w_inc;
    logic [CW-1:0]  pairs, pairs_m1, h_m1;
    logic [2:0]     pad_wt [CW];
    logic [6:0]     res_sum, res_a, res_b, res_c, res_d;
    logic [3:0]     pad_raw;

    // weight of each pair-count bit in the row byte count, modulo the alignment
    for (genvar g = 0; g < CW; g++) begin : g_wt
        localparam int WT = (PB << g) % ROW_ALIGN;
        assign pad_wt[g] = 3'(WT);
    end

    // width clamp and pair count
    always_comb begin
        if (cfg_wdata < 13'd2) begin
            w_clamped = 13'd2;
        end else if (cfg_wdata > 13'(WIDTH_TOP)) begin
            w_clamped = 13'(WIDTH_TOP);
        end else begin
            w_clamped = cfg_wdata;
        end
        w_inc    = {1'b0, w_clamped} + 14'd1;
        pairs    = w_inc[CW:1];
        pairs_m1 = pairs - 13'd1;
    end

    // row byte count modulo the alignment, then the pad length
    always_comb begin
        res_sum = 7'd0;
        for (int i = 0; i < CW; i++) begin
            if (pairs[i]) begin
                res_sum = res_sum + 7'(pad_wt[i]);
            end
        end
        res_a   = (res_sum >= ALIGN_X8) ? res_sum - ALIGN_X8 : res_sum;
        res_b   = (res_a >= ALIGN_X4) ? res_a - ALIGN_X4 : res_a;
        res_c   = (res_b >= ALIGN_X2) ? res_b - ALIGN_X2 : res_b;
        res_d   = (res_c >= ALIGN_X1) ? res_c - ALIGN_X1 : res_c;
        pad_raw = (res_d == 7'd0) ? 4'd0 : 4'(ROW_ALIGN) - res_d[3:0];
    end

    // height clamp
    always_comb begin
        if (cfg_wdata == 13'd0) begin
            h_clamped = 13'd1;
        end else if (cfg_wdata > 13'(y2r_pkg::HEIGHT_CAP)) begin
            h_clamped = 13'(y2r_pkg::HEIGHT_CAP);
        end else begin
            h_clamped = cfg_wdata;
        end
        h_m1 = h_clamped - 13'd1;
    end

    // register writes
    always_comb begin
        pairs_last_next = pairs_last_reg;
        rows_last_next  = rows_last_reg;
        pad_next        = pad_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                y2r_pkg::REG_FRAME_WIDTH: begin
                    pairs_last_next = PAIR_W'(pairs_m1);
                    pad_next = (pad_raw > 4'(y2r_pkg::PAD_LIMIT)) ?
                               y2r_pkg::PAD_W'(y2r_pkg::PAD_LIMIT) : y2r_pkg::PAD_W'(pad_raw);
                end
                y2r_pkg::REG_FRAME_HEIGHT: begin
                    rows_last_next = h_m1[y2r_pkg::ROW_W-1:0];
                end
                default: begin
                    pairs_last_next = pairs_last_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pairs_last_reg <= PAIR_W'(RST_PAIRS - 1);
            rows_last_reg  <= y2r_pkg::ROW_W'(y2r_pkg::RESET_HEIGHT - 1);
            pad_reg        <= y2r_pkg::PAD_W'(RST_PAD);
        end else begin
            pairs_last_reg <= pairs_last_next;
            rows_last_reg  <= rows_last_next;
            pad_reg        <= pad_next;
        end
    end

    // front end, queue, back end
    logic                q_push, q_push_ready, q_valid, q_pop;
    y2r_pkg::y2r_entry_t push_entry, head_entry;

    y2r_front #(
        .PAIR_W (PAIR_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .pairs_last (pairs_last_reg),
        .rows_last  (rows_last_reg),
        .pad_cnt    (pad_reg),
        .q_ready    (q_push_ready),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    y2r_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .push_ready (q_push_ready),
        .q_valid    (q_valid),
        .q_entry    (head_entry),
        .pop        (q_pop)
    );

    y2r_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- sim/y2r_byte_checker.sv -----
// checker for the yuyv to rgb24 converter: predicts every output beat and compares it
`timescale 1ns / 1ps

module y2r_byte_checker #(
    parameter int ROW_PIXELS_MAX = 4096,
    parameter int ROW_ALIGN = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // luma_first, chroma_blue, luma_second, chroma_red
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [7:0]                  m_tdata,   // out_byte
    input  logic                        m_tlast,
    input  logic [2:0]                  m_tuser,   // is_padding, last_of_item, frame_end
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [y2r_pkg::CFG_W-1:0]   cfg_wdata,
    output int                          pending_beats,
    output int                          fault_count
);

    // one output beat with all its flags
    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_pad;
        logic       item_last;
        logic       row_last;
        logic       frame_last;
    } bgr_beat_t;

    bgr_beat_t        bgr_bytes_due[$];
    bgr_beat_t        pair_beats[8];
    bgr_beat_t        got_beat;
    bgr_beat_t        want_beat;

    logic [y2r_pkg::CFG_W-1:0] width_reg;
    logic [y2r_pkg::CFG_W-1:0] height_reg;
    int               pair_col;
    int               row_idx;
    int               faults = 0;

    int               y_lo, y_hi, u_off, v_off;
    int               r_add, g_add, b_add;
    int               w_eff, h_eff, pairs, pad_n, n_beats;
    logic             row_done, frame_done;

    // saturate a colour sum to one byte
    function automatic logic [7:0] sat_byte(input int x);
        if (x < 0)
            return 8'h00;
        if (x > int'(y2r_pkg::BYTE_MAX))
            return y2r_pkg::BYTE_MAX;
        return x[7:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = y2r_pkg::CFG_W'(y2r_pkg::RESET_WIDTH);
            height_reg = y2r_pkg::CFG_W'(y2r_pkg::RESET_HEIGHT);
            pair_col   = 0;
            row_idx    = 0;
            bgr_bytes_due.delete();
        end else begin
            // register writes
            if (cfg_wr_en) begin
                if (cfg_index == y2r_pkg::REG_FRAME_WIDTH)
                    width_reg = cfg_wdata;
                else
                    height_reg = cfg_wdata;
            end

            // accepted pair: work out its colour bytes, padding and flags
            if (s_tvalid && s_tready) begin
                y_lo  = int'(s_tdata[7:0]);
                u_off = int'(s_tdata[15:8]) - int'(y2r_pkg::CHROMA_BIAS);
                y_hi  = int'(s_tdata[23:16]);
                v_off = int'(s_tdata[31:24]) - int'(y2r_pkg::CHROMA_BIAS);

                // arithmetic shifts floor towards minus infinity
                r_add = v_off + ((int'(y2r_pkg::K_R_V) * v_off) >>> 8);
                g_add = -((int'(y2r_pkg::K_G_U) * u_off) >>> 8)
                        - ((int'(y2r_pkg::K_G_V) * v_off) >>> 8);
                b_add = u_off + ((int'(y2r_pkg::K_B_U) * u_off) >>> 8);

                // effective geometry, odd width rounds up to whole pairs
                w_eff = int'(width_reg);
                if (w_eff < 2)
                    w_eff = 2;
                if (w_eff > ROW_PIXELS_MAX)
                    w_eff = ROW_PIXELS_MAX;
                pairs = (w_eff + 1) / 2;
                h_eff = int'(height_reg);
                if (h_eff < 1)
                    h_eff = 1;
                if (h_eff > y2r_pkg::HEIGHT_CAP)
                    h_eff = y2r_pkg::HEIGHT_CAP;

                for (int k = 0; k < 8; k++)
                    pair_beats[k] = '0;
                pair_beats[0].byte_val = sat_byte(y_lo + b_add);
                pair_beats[1].byte_val = sat_byte(y_lo + g_add);
                pair_beats[2].byte_val = sat_byte(y_lo + r_add);
                pair_beats[3].byte_val = sat_byte(y_hi + b_add);
                pair_beats[4].byte_val = sat_byte(y_hi + g_add);
                pair_beats[5].byte_val = sat_byte(y_hi + r_add);
                n_beats = y2r_pkg::BYTES_PER_PAIR;

                // a position past a shrunk frame ends the row at once
                row_done   = (pair_col + 1 >= pairs);
                frame_done = row_done && (row_idx + 1 >= h_eff);

                if (row_done) begin
                    pad_n = (y2r_pkg::BYTES_PER_PAIR * pairs) % ROW_ALIGN;
                    if (pad_n != 0)
                        pad_n = ROW_ALIGN - pad_n;
                    if (pad_n > y2r_pkg::PAD_LIMIT)
                        pad_n = y2r_pkg::PAD_LIMIT;
                    for (int k = 0; k < pad_n; k++) begin
                        pair_beats[n_beats].is_pad = 1'b1;
                        n_beats++;
                    end
                    pair_col = 0;
                    row_idx  = frame_done ? 0 : row_idx + 1;
                end else begin
                    pair_col = pair_col + 1;
                end

                pair_beats[n_beats-1].item_last  = 1'b1;
                pair_beats[n_beats-1].row_last   = row_done;
                pair_beats[n_beats-1].frame_last = frame_done;
                for (int k = 0; k < n_beats; k++)
                    bgr_bytes_due.push_back(pair_beats[k]);
            end

            // output beat against the oldest expectation
            if (m_tvalid && m_tready) begin
                got_beat.byte_val   = m_tdata;
                got_beat.is_pad     = m_tuser[0];
                got_beat.item_last  = m_tuser[1];
                got_beat.row_last   = m_tlast;
                got_beat.frame_last = m_tuser[2];
                if (bgr_bytes_due.size() == 0) begin
                    faults++;
                    if (faults <= 10)
                        $display("unexpected beat: byte %02h pad %0b item %0b row %0b frame %0b",
                                 got_beat.byte_val, got_beat.is_pad, got_beat.item_last,
                                 got_beat.row_last, got_beat.frame_last);
                end else begin
                    want_beat = bgr_bytes_due.pop_front();
                    if (got_beat !== want_beat) begin
                        faults++;
                        if (faults <= 10)
                            $display({"beat mismatch: expected byte %02h pad %0b item %0b ",
                                      "row %0b frame %0b, got byte %02h pad %0b item %0b ",
                                      "row %0b frame %0b"},
                                     want_beat.byte_val, want_beat.is_pad, want_beat.item_last,
                                     want_beat.row_last, want_beat.frame_last,
                                     got_beat.byte_val, got_beat.is_pad, got_beat.item_last,
                                     got_beat.row_last, got_beat.frame_last);
                    end
                end
            end
        end
        pending_beats <= bgr_bytes_due.size();
        fault_count   <= faults;
    end

endmodule

// ----- sim/tb_yuyv_to_rgb24_converter.sv -----
// testbench top for the yuyv to rgb24 converter: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_yuyv_to_rgb24_converter;

    localparam int MAX_W        = 4096;
    localparam int ALIGN        = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int CW           = y2r_pkg::CFG_W;

    // receiver stall patterns
    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [7:0]         m_tdata;
    logic               m_tlast;
    logic [2:0]         m_tuser;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = y2r_pkg::REG_FRAME_WIDTH;
    logic [CW-1:0]      cfg_wdata = '0;

    int                 pending_beats;
    int                 fault_count;
    int                 burst_left = 0;
    int                 stall_left = 0;
    int unsigned        rx_tick    = 0;
    rx_mode_t           stall_mode = RX_ALWAYS;

    always #10 aclk = ~aclk;

    yuyv_to_rgb24_converter #(
        .ROW_PIXELS_MAX (MAX_W),
        .ROW_ALIGN      (ALIGN)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    y2r_byte_checker #(
        .ROW_PIXELS_MAX (MAX_W),
        .ROW_ALIGN      (ALIGN)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .pending_beats (pending_beats),
        .fault_count   (fault_count)
    );

    // receiver stalls, switching to a random pattern whenever the stall_left countdown runs out
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (stall_left == 0) begin
            stall_mode = rx_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 80);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
            default:     m_tready <= (rx_tick[2:0] != 3'd0) && (rx_tick[2:0] != 3'd4);
        endcase
    end

    // run limit
    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // offer one pair, in bursts with random gaps between them
    task automatic send_pair(input logic [31:0] word);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // stop sending and wait for every expected beat to leave
    task automatic wait_drained;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_beats != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic idx, input logic [CW-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // new frame size, only once the block is idle
    task automatic set_geometry(input int w, input int h);
        wait_drained();
        write_reg(y2r_pkg::REG_FRAME_WIDTH, w[CW-1:0]);
        write_reg(y2r_pkg::REG_FRAME_HEIGHT, h[CW-1:0]);
    endtask

    // byte with a bias towards the extremes and the chroma midpoint
    function automatic logic [7:0] pick_byte;
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return y2r_pkg::CHROMA_BIAS;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // random pairs, optionally pausing halfway until the output runs dry
    task automatic run_pairs(input int count, input bit pause_midway);
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2)
                wait_drained();
            send_pair({pick_byte(), pick_byte(), pick_byte(), pick_byte()});
        end
    endtask

    initial begin
        int w_pick;
        int h_pick;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // geometry straight after reset
        send_pair(32'h8080_8080);
        send_pair(32'h80EB_8010);

        // one pair per frame, extremes of luma and chroma
        set_geometry(2, 1);
        send_pair(32'h0000_0000);
        send_pair(32'hFFFF_FFFF);
        send_pair(32'hFF00_FF00);
        send_pair(32'h00FF_00FF);
        send_pair(32'h00FF_FF00);
        send_pair(32'hFF00_00FF);
        send_pair(32'h7F01_7F01);
        send_pair(32'h817F_7F81);
        send_pair(32'h80EB_8010);

        // width and height of zero fall back to the smallest frame
        set_geometry(0, 0);
        send_pair(32'h4080_C080);
        send_pair(32'hC040_40C0);

        // odd width rounds up to a whole pair
        set_geometry(3, 2);
        repeat (4) send_pair($urandom);

        // oversize values clamp, then a shrink leaves the position past the row
        set_geometry(8191, 8191);
        repeat (3) send_pair($urandom);
        set_geometry(2, 1);
        send_pair($urandom);

        // random part: random content over several frame sizes, whole frames or not
        set_geometry(4096, 4096);
        run_pairs(6, 1'b0);
        set_geometry(6, 3);
        run_pairs(18, 1'b1);
        set_geometry(10, 2);
        run_pairs(15, 1'b0);
        set_geometry(2, 4096);
        run_pairs(20, 1'b0);
        set_geometry(2, 1);
        run_pairs(3, 1'b0);
        for (int p = 0; p < 4; p++) begin
            w_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 18)
                                                 : 2 * $urandom_range(1, 9);
            h_pick = $urandom_range(1, 3);
            set_geometry(w_pick, h_pick);
            run_pairs(((w_pick + 1) / 2) * h_pick + $urandom_range(0, 3), 1'b0);
        end

        // drain and give the verdict
        wait_drained();
        if (fault_count == 0 && pending_beats == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/y2r_pkg.sv
hw/rtl/y2r_queue.sv
hw/rtl/y2r_front.sv
hw/rtl/y2r_back.sv
hw/rtl/yuyv_to_rgb24_converter.sv
sim/y2r_byte_checker.sv
sim/tb_yuyv_to_rgb24_converter.sv
